// File: hdl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths and constants for the path segment densifier.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int COORD_W      = 28;            // Q12.16 coordinate
  localparam int DIFF_W       = COORD_W + 1;   // signed per-axis difference
  localparam int SPC_W        = 16;            // spacing register
  localparam int SQ_W         = 2 * COORD_W + 2; // sum of three squares
  localparam int ROOT_W       = SQ_W / 2;      // integer square root
  localparam int DIVD_W       = ROOT_W;        // divider dividend width
  localparam int MAX_FILL_DEF = 62;

  localparam logic [SPC_W-1:0] SPACING_RESET = 16'd1311;

endpackage

// File: hdl/psd_div.sv
// ----------------------------------------------------------------------------
// psd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psd_div
  import psd_pkg::*;
#(
  parameter int NW = DIVD_W,
  parameter int DW = SPC_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW-1:0] dvs;
  logic [DW:0]   sh;
  logic          fits;

  assign sh   = {rem, quot[NW-1]};
  assign fits = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CW'(NW - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quot <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (fits) begin
          rem <= DW'(sh - {1'b0, dvs});
        end else begin
          rem <= sh[DW-1:0];
        end
        quot <= {quot[NW-2:0], fits};
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

// File: hdl/psd_sqrt.sv
// ----------------------------------------------------------------------------
// psd_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module psd_sqrt
  import psd_pkg::*;
#(
  parameter int IW = SQ_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IW-1:0]     radicand,
  output logic              done,
  output logic [IW/2-1:0]   root
);

  localparam int RW = IW / 2;
  localparam int CW = $clog2(RW + 1);

  logic [CW-1:0] cnt;
  logic          busy;
  logic [IW-1:0] op;
  logic [RW+1:0] rem;
  logic [RW+1:0] sh;
  logic [RW+1:0] trial;
  logic          fits;

  assign sh    = {rem[RW-1:0], op[IW-1:IW-2]};
  assign trial = {root, 2'b01};
  assign fits  = sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CW'(RW - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        op   <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rem  <= fits ? sh - trial : sh;
        root <= {root[RW-2:0], fits};
        op   <= {op[IW-3:0], 2'b00};
        if (cnt == CW'(RW - 1)) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

// File: hdl/path_segment_densifier_top.sv
// ----------------------------------------------------------------------------
// path_segment_densifier_top
// Emits each held waypoint followed by evenly spaced fill points toward the
// next waypoint, so that no gap exceeds max_spacing unless the fill count is clamped to MaxFill.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | in_valid, in_stall | way_x, way_y, way_z, path_last
//  output   | out_valid,out_stall| pt_x, pt_y, pt_z, pt_kind, fill_clamped,
//           |                    | path_end, run_last
//  config   | cfg_we             | cfg_wdata (max_spacing)
//
// A segment squares its differences in one shared multiplier, takes their
// square root in one root unit and then runs four divisions (count, x, y, z;
// skipped when no fill is needed) in one divider before it emits its points.
// in_stall is high from acceptance until the last point is loaded into the
// output register, or until a first waypoint is held. Output stalls hold the
// block. Reset is synchronous and empties the held waypoint.
module path_segment_densifier_top
  import psd_pkg::*;
#(
  parameter int MaxFill = MAX_FILL_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] way_x,
  input  logic signed [COORD_W-1:0] way_y,
  input  logic signed [COORD_W-1:0] way_z,
  input  logic                      path_last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] pt_x,
  output logic signed [COORD_W-1:0] pt_y,
  output logic signed [COORD_W-1:0] pt_z,
  output logic                      pt_kind,
  output logic                      fill_clamped,
  output logic                      path_end,
  output logic                      run_last,
  input  logic                      cfg_we,
  input  logic [SPC_W-1:0]          cfg_wdata
);

  localparam int NW = $clog2(MaxFill + 2);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_SQ, S_SQRT, S_DIVN, S_DIVX, S_DIVY, S_DIVZ,
    S_EPREV, S_EMID, S_ELAST
  } state_t;

  state_t state;

  logic [SPC_W-1:0] max_spacing;
  logic             have_prev;
  logic signed [COORD_W-1:0] prev [3];
  logic signed [COORD_W-1:0] way [3];
  logic             last_r;

  logic [COORD_W-1:0] absd [3];
  logic               negd [3];
  logic [1:0]         k;
  logic [2*COORD_W-1:0] prod;
  logic [SQ_W-1:0]    acc;

  logic [NW-1:0]      n_cnt;
  logic [NW-1:0]      j;
  logic [NW-1:0]      div_n;
  logic               clamped;
  logic [COORD_W-1:0] qd [3];
  logic [NW-1:0]      rd [3];
  logic [COORD_W-1:0] q [3];
  logic [NW-1:0]      r [3];

  logic               sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]  gap;
  logic               div_start, div_done;
  logic [DIVD_W-1:0]  div_a, quot;
  logic [SPC_W-1:0]   div_b, remd;

  logic               slot_free;
  logic [SPC_W-1:0]   sp;
  logic [NW-1:0]      n_sel;
  logic               clamp_sel;
  logic [COORD_W-1:0] mul_a;
  logic               load;
  logic               sqrt_go;
  logic               div_go;

  psd_sqrt #(.IW(SQ_W)) u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(acc),
    .done(sqrt_done), .root(gap)
  );

  psd_div #(.NW(DIVD_W), .DW(SPC_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quot(quot), .rem(remd)
  );

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;
  assign sp        = (max_spacing == '0) ? SPC_W'(1) : max_spacing;
  assign clamp_sel = quot > DIVD_W'(MaxFill);
  assign n_sel     = clamp_sel ? NW'(MaxFill) : quot[NW-1:0];
  assign mul_a     = (k == 2'd0) ? absd[0] : (k == 2'd1) ? absd[1] : absd[2];
  assign load      = slot_free && (state inside {S_EPREV, S_EMID, S_ELAST});
  assign sqrt_go   = (state == S_SQ) && (k == 2'd3);
  // The divider restarts after the root when fill is needed, and after each
  // division except the last one.
  assign div_go    = ((state == S_SQRT) && sqrt_done && (gap > ROOT_W'(sp))) ||
                     ((state inside {S_DIVN, S_DIVX, S_DIVY}) && div_done);

  // Fill point of one axis: prev plus or minus the truncated fraction.
  function automatic logic [COORD_W-1:0] fill_pt(
    input logic signed [COORD_W-1:0] p, input logic [COORD_W-1:0] m,
    input logic neg
  );
    logic [DIFF_W-1:0] s;
    s = neg ? {p[COORD_W-1], p} - {1'b0, m} : {p[COORD_W-1], p} + {1'b0, m};
    return s[COORD_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      max_spacing <= SPACING_RESET;
      have_prev   <= 1'b0;
      out_valid   <= 1'b0;
      sqrt_start  <= 1'b0;
      div_start   <= 1'b0;
      n_cnt       <= '0;
      for (int i = 0; i < 3; i++) begin
        prev[i] <= '0;
      end
    end else begin
      sqrt_start <= sqrt_go;
      div_start  <= div_go;
      if (cfg_we) begin
        max_spacing <= cfg_wdata;
      end
      if (out_valid && !out_stall && !load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            way[0] <= way_x;
            way[1] <= way_y;
            way[2] <= way_z;
            last_r <= path_last;
            state  <= S_START;
          end
        end
        S_START: begin
          if (!have_prev) begin
            if (last_r) begin
              state <= S_ELAST;
            end else begin
              prev      <= way;
              have_prev <= 1'b1;
              state     <= S_IDLE;
            end
          end else begin
            for (int i = 0; i < 3; i++) begin
              logic signed [DIFF_W-1:0] d;
              d = DIFF_W'(way[i]) - DIFF_W'(prev[i]);
              negd[i] <= d[DIFF_W-1];
              absd[i] <= d[DIFF_W-1] ? COORD_W'(-d) : d[COORD_W-1:0];
            end
            k     <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          // Squares go through one registered multiplier and accumulate.
          prod <= mul_a * mul_a;
          if (k == 2'd1) begin
            acc <= SQ_W'(prod);
          end else if (k != 2'd0) begin
            acc <= acc + SQ_W'(prod);
          end
          if (k == 2'd3) begin
            state <= S_SQRT;
          end
          k <= k + 1'b1;
        end
        S_SQRT: begin
          if (sqrt_done) begin
            if (gap > ROOT_W'(sp)) begin
              div_a <= gap - 1'b1;
              div_b <= sp;
              state <= S_DIVN;
            end else begin
              n_cnt   <= '0;
              clamped <= 1'b0;
              state   <= S_EPREV;
            end
          end
        end
        S_DIVN: begin
          if (div_done) begin
            n_cnt   <= n_sel;
            clamped <= clamp_sel;
            div_n   <= n_sel + 1'b1;
            div_a   <= DIVD_W'(absd[0]);
            div_b   <= SPC_W'(n_sel + 1'b1);
            state   <= S_DIVX;
          end
        end
        S_DIVX, S_DIVY: begin
          if (div_done) begin
            if (state == S_DIVX) begin
              qd[0] <= quot[COORD_W-1:0];
              rd[0] <= remd[NW-1:0];
              div_a <= DIVD_W'(absd[1]);
              state <= S_DIVY;
            end else begin
              qd[1] <= quot[COORD_W-1:0];
              rd[1] <= remd[NW-1:0];
              div_a <= DIVD_W'(absd[2]);
              state <= S_DIVZ;
            end
          end
        end
        S_DIVZ: begin
          if (div_done) begin
            qd[2] <= quot[COORD_W-1:0];
            rd[2] <= remd[NW-1:0];
            q[0]  <= qd[0];
            r[0]  <= rd[0];
            q[1]  <= qd[1];
            r[1]  <= rd[1];
            q[2]  <= quot[COORD_W-1:0];
            r[2]  <= remd[NW-1:0];
            j     <= NW'(1);
            state <= S_EPREV;
          end
        end
        S_EPREV: begin
          if (slot_free) begin
            out_valid    <= 1'b1;
            pt_x         <= prev[0];
            pt_y         <= prev[1];
            pt_z         <= prev[2];
            pt_kind      <= 1'b0;
            fill_clamped <= clamped;
            path_end     <= 1'b0;
            run_last     <= (n_cnt == '0) && !last_r;
            if (n_cnt != '0) begin
              state <= S_EMID;
            end else if (last_r) begin
              state <= S_ELAST;
            end else begin
              prev  <= way;
              state <= S_IDLE;
            end
          end
        end
        S_EMID: begin
          if (slot_free) begin
            out_valid    <= 1'b1;
            pt_x         <= fill_pt(prev[0], q[0], negd[0]);
            pt_y         <= fill_pt(prev[1], q[1], negd[1]);
            pt_z         <= fill_pt(prev[2], q[2], negd[2]);
            pt_kind      <= 1'b1;
            fill_clamped <= clamped;
            path_end     <= 1'b0;
            run_last     <= (j == n_cnt) && !last_r;
            // Step each axis from j*|d|/(n+1) to (j+1)*|d|/(n+1).
            for (int i = 0; i < 3; i++) begin
              logic [NW:0] rs;
              rs = {1'b0, r[i]} + {1'b0, rd[i]};
              if (rs >= {1'b0, div_n}) begin
                r[i] <= NW'(rs - {1'b0, div_n});
                q[i] <= q[i] + qd[i] + 1'b1;
              end else begin
                r[i] <= rs[NW-1:0];
                q[i] <= q[i] + qd[i];
              end
            end
            j <= j + 1'b1;
            if (j == n_cnt) begin
              if (last_r) begin
                state <= S_ELAST;
              end else begin
                prev  <= way;
                state <= S_IDLE;
              end
            end
          end
        end
        S_ELAST: begin
          if (slot_free) begin
            out_valid    <= 1'b1;
            pt_x         <= way[0];
            pt_y         <= way[1];
            pt_z         <= way[2];
            pt_kind      <= 1'b0;
            fill_clamped <= 1'b0;
            path_end     <= 1'b1;
            run_last     <= 1'b1;
            have_prev    <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("request taken while idle");
  a_fill_not_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && pt_kind |-> !path_end) else $error("fill point marked path end");
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && path_end |-> run_last) else $error("path end not last result");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    n_cnt <= NW'(MaxFill)) else $error("fill count above limit");

endmodule
